### sv/sct_pkg.sv
package sct_pkg;

  // token kind codes
  localparam logic [5:0] K_END        = 6'd0;
  localparam logic [5:0] K_NEWLINE    = 6'd1;
  localparam logic [5:0] K_LPAREN     = 6'd2;
  localparam logic [5:0] K_RPAREN     = 6'd3;
  localparam logic [5:0] K_LBRACE     = 6'd4;
  localparam logic [5:0] K_RBRACE     = 6'd5;
  localparam logic [5:0] K_LSQUARE    = 6'd6;
  localparam logic [5:0] K_RSQUARE    = 6'd7;
  localparam logic [5:0] K_COMMA      = 6'd8;
  localparam logic [5:0] K_DOT        = 6'd9;
  localparam logic [5:0] K_COLON      = 6'd10;
  localparam logic [5:0] K_MINUS      = 6'd11;
  localparam logic [5:0] K_PLUS       = 6'd12;
  localparam logic [5:0] K_SLASH      = 6'd13;
  localparam logic [5:0] K_STAR       = 6'd14;
  localparam logic [5:0] K_EQUAL      = 6'd15;
  localparam logic [5:0] K_LOWER      = 6'd16;
  localparam logic [5:0] K_HIGHER     = 6'd17;
  localparam logic [5:0] K_RARROW     = 6'd18;
  localparam logic [5:0] K_DRARROW    = 6'd19;
  localparam logic [5:0] K_EQEQ       = 6'd20;
  localparam logic [5:0] K_BIGARROW   = 6'd21;
  localparam logic [5:0] K_LARROW     = 6'd22;
  localparam logic [5:0] K_LE         = 6'd23;
  localparam logic [5:0] K_GE         = 6'd24;
  localparam logic [5:0] K_STRING     = 6'd25;
  localparam logic [5:0] K_NUMBER     = 6'd26;
  localparam logic [5:0] K_IDENT      = 6'd27;
  localparam logic [5:0] K_KEYWORD0   = 6'd28;
  localparam logic [5:0] K_ERR_BYTE   = 6'd40;
  localparam logic [5:0] K_ERR_STRING = 6'd41;
  localparam logic [5:0] K_LAST       = K_ERR_STRING;

  localparam int unsigned NUM_KEYWORDS = 12;
  localparam int unsigned MAX_TOKENS   = 3;

  // keyword text, byte i at bits 8i
  localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
    48'h0000_6575_7274,  // true
    48'h0065_736c_6166,  // false
    48'h0000_0000_726f,  // or
    48'h0000_0064_6e61,  // and
    48'h0000_0000_6669,  // if
    48'h0000_6573_6c65,  // else
    48'h0000_0072_6f66,  // for
    48'h0065_6c69_6877,  // while
    48'h0000_656e_6f6e,  // none
    48'h0073_7361_6c63,  // class
    48'h0000_666c_6573,  // self
    48'h6c6c_6f72_6e75   // unroll
  };
  localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
    3'd4, 3'd5, 3'd2, 3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd4, 3'd6
  };

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        last_of_run;
  } out_item_t;

  // tokens caused by one input item, oldest in slot 0
  typedef struct packed {
    logic [1:0]           count;
    out_item_t [2:0]      tok;
  } bundle_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    bundle_t data;
  } queue_head_t;

  // identifier or keyword kind from the stored prefix
  function automatic logic [5:0] word_kind(input logic [47:0] prefix, input logic [2:0] len);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
        kind = K_KEYWORD0 + 6'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic char_is_numeral(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic char_is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
  endfunction

endpackage

### sv/source_code_tokenizer.sv
// Streaming source tokenizer. One source byte or end marker enters per cycle
// unless in_stall_o is high. The scanner knows a token has ended only on the byte
// after it, so one item can emit up to three tokens, which leave one per cycle
// unless out_stall_i is high, through a two-entry queue and an output register.
// Input throughput is one item per cycle while each item yields at most one token
// and out_stall_i is low; items that emit two or three tokens take one output slot
// per token, and the queue absorbs that until it fills, then in_stall_o rises.
// The first token of an item goes through the queue, then the output register.
// The end marker flushes any pending token, emits an end token, resets the scanner.
module source_code_tokenizer #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LINE_BITS     = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sct_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sct_pkg::out_item_t out_item_o
);
  import sct_pkg::*;

  logic        accept, push, full, pop;
  bundle_t     bundle;
  queue_head_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sct_front #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .push_o  (push),
    .bundle_o(bundle)
  );

  sct_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(bundle),
    .full_o(full),
    .head_o(head),
    .pop_i (pop)
  );

  sct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

### sv/sct_front.sv
module sct_front #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LINE_BITS     = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sct_pkg::in_item_t item_i,
  output logic              push_o,
  output sct_pkg::bundle_t  bundle_o
);
  import sct_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]     LINE_MAX = {LINE_BITS{1'b1}};

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_SDQ, M_SSQ, M_SDQ_ESC, M_SSQ_ESC, M_NUM, M_NUMDOT,
    M_FRAC, M_WORD, M_MINUS, M_ARROW, M_EQ, M_LT, M_GT
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic       set_origin;
    logic       origin_next;
    logic       word_init;
    logic       emit;
    logic [5:0] kind;
    logic       inc_line;
  } start_t;

  typedef struct packed {
    logic                     valid;
    logic [5:0]               kind;
    logic [POSITION_BITS-1:0] start;
    logic [15:0]              length;
    logic [LINE_BITS-1:0]     line;
  } slot_t;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, origin_q, origin_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic [47:0]              prefix_q, prefix_d;
  logic [2:0]               wlen_q, wlen_d;

  logic [POSITION_BITS-1:0] pos_nxt, pos_prev;
  logic [LINE_BITS-1:0]     line_inc;
  logic [7:0]               c;
  start_t                   st;
  logic                     do_start;
  slot_t [2:0]              slot;

  function automatic logic [15:0] span(input logic [POSITION_BITS-1:0] from,
                                       input logic [POSITION_BITS-1:0] to);
    logic [POSITION_BITS-1:0] d;
    d = to - from;
    if (to <= from) return 16'd0;
    if (d > POSITION_BITS'(16'hFFFF)) return 16'hFFFF;
    return d[15:0];
  endfunction

  function automatic logic [23:0] line_out(input logic [LINE_BITS-1:0] l);
    if (LINE_BITS > 24 && l > LINE_BITS'(24'hFFFFFF)) return 24'hFFFFFF;
    return 24'(l);
  endfunction

  // first byte of a token: classify
  function automatic start_t classify(input logic [7:0] b);
    start_t s;
    s = '{mode: M_IDLE, set_origin: 1'b0, origin_next: 1'b0, word_init: 1'b0,
          emit: 1'b0, kind: K_ERR_BYTE, inc_line: 1'b0};
    unique case (b)
      8'h20, 8'h0d, 8'h09: ;
      8'h0a: begin s.inc_line = 1'b1; s.emit = 1'b1; s.kind = K_NEWLINE; end
      8'h23: s.mode = M_COMMENT;
      8'h28: begin s.emit = 1'b1; s.kind = K_LPAREN;  end
      8'h29: begin s.emit = 1'b1; s.kind = K_RPAREN;  end
      8'h7b: begin s.emit = 1'b1; s.kind = K_LBRACE;  end
      8'h7d: begin s.emit = 1'b1; s.kind = K_RBRACE;  end
      8'h5b: begin s.emit = 1'b1; s.kind = K_LSQUARE; end
      8'h5d: begin s.emit = 1'b1; s.kind = K_RSQUARE; end
      8'h2c: begin s.emit = 1'b1; s.kind = K_COMMA;   end
      8'h2e: begin s.emit = 1'b1; s.kind = K_DOT;     end
      8'h3a: begin s.emit = 1'b1; s.kind = K_COLON;   end
      8'h2b: begin s.emit = 1'b1; s.kind = K_PLUS;    end
      8'h2f: begin s.emit = 1'b1; s.kind = K_SLASH;   end
      8'h2a: begin s.emit = 1'b1; s.kind = K_STAR;    end
      8'h2d: begin s.mode = M_MINUS; s.set_origin = 1'b1; end
      8'h3d: begin s.mode = M_EQ;    s.set_origin = 1'b1; end
      8'h3c: begin s.mode = M_LT;    s.set_origin = 1'b1; end
      8'h3e: begin s.mode = M_GT;    s.set_origin = 1'b1; end
      8'h22: begin s.mode = M_SDQ; s.set_origin = 1'b1; s.origin_next = 1'b1; end
      8'h27: begin s.mode = M_SSQ; s.set_origin = 1'b1; s.origin_next = 1'b1; end
      default: begin
        if (char_is_numeral(b)) begin
          s.mode = M_NUM; s.set_origin = 1'b1;
        end else if (char_is_letter(b)) begin
          s.mode = M_WORD; s.set_origin = 1'b1; s.word_init = 1'b1;
        end else begin
          s.emit = 1'b1;
        end
      end
    endcase
    return s;
  endfunction

  assign c        = item_i.source_byte;
  assign pos_nxt  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign pos_prev = pos_q - 1'b1;
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
  assign st       = classify(c);

  // scanner next state and emitted tokens
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_nxt;
    origin_d = origin_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    do_start = 1'b0;
    slot     = '0;
    slot[0].line = line_q;
    slot[1].line = line_q;
    slot[2].line = line_q;
    if (item_i.end_of_source) begin
      unique case (mode_q)
        M_SDQ, M_SSQ, M_SDQ_ESC, M_SSQ_ESC: begin
          slot[0] = '{1'b1, K_ERR_STRING, origin_q, span(origin_q, pos_q), line_q};
        end
        M_NUM, M_FRAC: slot[0] = '{1'b1, K_NUMBER, origin_q, span(origin_q, pos_q), line_q};
        M_NUMDOT: begin
          slot[0] = '{1'b1, K_NUMBER, origin_q, span(origin_q, pos_prev), line_q};
          slot[1] = '{1'b1, K_DOT, pos_prev, 16'd1, line_q};
        end
        M_WORD: begin
          slot[0] = '{1'b1, word_kind(prefix_q, wlen_q), origin_q, span(origin_q, pos_q), line_q};
        end
        M_MINUS: slot[0] = '{1'b1, K_MINUS, origin_q, 16'd1, line_q};
        M_ARROW: slot[0] = '{1'b1, K_RARROW, origin_q, span(origin_q, pos_q), line_q};
        M_EQ:    slot[0] = '{1'b1, K_EQUAL, origin_q, 16'd1, line_q};
        M_LT:    slot[0] = '{1'b1, K_LOWER, origin_q, 16'd1, line_q};
        M_GT:    slot[0] = '{1'b1, K_HIGHER, origin_q, 16'd1, line_q};
        default: ;
      endcase
      slot[2]  = '{1'b1, K_END, pos_q, 16'd0, line_q};
      mode_d   = M_IDLE;
      pos_d    = '0;
      origin_d = '0;
      line_d   = LINE_BITS'(1);
      prefix_d = '0;
      wlen_d   = '0;
    end else begin
      unique case (mode_q)
        M_COMMENT: do_start = (c == 8'h0a);
        M_SDQ, M_SSQ: begin
          if (c == ((mode_q == M_SDQ) ? 8'h22 : 8'h27)) begin
            slot[0] = '{1'b1, K_STRING, origin_q, span(origin_q, pos_q), line_q};
            mode_d  = M_IDLE;
          end else if (c == 8'h5c) begin
            mode_d = (mode_q == M_SDQ) ? M_SDQ_ESC : M_SSQ_ESC;
          end else if (c == 8'h0a) begin
            line_d = line_inc;
          end
        end
        M_SDQ_ESC, M_SSQ_ESC: begin
          if (c == 8'h0a) line_d = line_inc;
          mode_d = (mode_q == M_SDQ_ESC) ? M_SDQ : M_SSQ;
        end
        M_NUM: begin
          if (c == 8'h2e) begin
            mode_d = M_NUMDOT;
          end else if (!char_is_numeral(c)) begin
            slot[0]  = '{1'b1, K_NUMBER, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (char_is_numeral(c)) begin
            mode_d = M_FRAC;
          end else begin
            slot[0]  = '{1'b1, K_NUMBER, origin_q, span(origin_q, pos_prev), line_q};
            slot[1]  = '{1'b1, K_DOT, pos_prev, 16'd1, line_q};
            do_start = 1'b1;
          end
        end
        M_FRAC: begin
          if (!char_is_numeral(c)) begin
            slot[0]  = '{1'b1, K_NUMBER, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        M_WORD: begin
          if (char_is_letter(c) || char_is_numeral(c)) begin
            for (int i = 0; i < 6; i++) begin
              if (wlen_q == 3'(i)) prefix_d[8*i +: 8] = c;
            end
            if (wlen_q != 3'd7) wlen_d = wlen_q + 3'd1;
          end else begin
            slot[0] = '{1'b1, word_kind(prefix_q, wlen_q), origin_q, span(origin_q, pos_q),
                        line_q};
            do_start = 1'b1;
          end
        end
        M_MINUS: begin
          if (c == 8'h3e) begin
            mode_d = M_ARROW;
          end else begin
            slot[0]  = '{1'b1, K_MINUS, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        M_ARROW: begin
          if (c == 8'h3e) begin
            slot[0] = '{1'b1, K_DRARROW, origin_q, span(origin_q, pos_nxt), line_q};
            mode_d  = M_IDLE;
          end else begin
            slot[0]  = '{1'b1, K_RARROW, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        M_EQ: begin
          if (c == 8'h3d || c == 8'h3e) begin
            slot[0] = '{1'b1, (c == 8'h3d) ? K_EQEQ : K_BIGARROW, origin_q,
                        span(origin_q, pos_nxt), line_q};
            mode_d  = M_IDLE;
          end else begin
            slot[0]  = '{1'b1, K_EQUAL, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        M_LT: begin
          if (c == 8'h2d || c == 8'h3d) begin
            slot[0] = '{1'b1, (c == 8'h2d) ? K_LARROW : K_LE, origin_q,
                        span(origin_q, pos_nxt), line_q};
            mode_d  = M_IDLE;
          end else begin
            slot[0]  = '{1'b1, K_LOWER, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        M_GT: begin
          if (c == 8'h3d) begin
            slot[0] = '{1'b1, K_GE, origin_q, span(origin_q, pos_nxt), line_q};
            mode_d  = M_IDLE;
          end else begin
            slot[0]  = '{1'b1, K_HIGHER, origin_q, span(origin_q, pos_q), line_q};
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
      // byte opens a new token
      if (do_start) begin
        mode_d = st.mode;
        if (st.inc_line) line_d = line_inc;
        if (st.set_origin) origin_d = st.origin_next ? pos_nxt : pos_q;
        if (st.word_init) begin
          prefix_d = {40'd0, c};
          wlen_d   = 3'd1;
        end
        slot[2] = '{st.emit, st.kind, pos_q, 16'd1,
                    st.inc_line ? line_inc : line_q};
      end
    end
  end

  // pack valid slots in order
  always_comb begin
    logic [1:0] n;
    n        = '0;
    bundle_o = '0;
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (slot[i].valid) begin
        bundle_o.tok[n] = '{slot[i].kind, 32'(slot[i].start), slot[i].length,
                            line_out(slot[i].line), 1'b0};
        n = n + 2'd1;
      end
    end
    bundle_o.count = n;
    push_o         = accept_i && (n != 2'd0);
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      origin_q <= '0;
      line_q   <= LINE_BITS'(1);
      prefix_q <= '0;
      wlen_q   <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      origin_q <= origin_d;
      line_q   <= line_d;
      prefix_q <= prefix_d;
      wlen_q   <= wlen_d;
    end
  end

endmodule

### sv/sct_queue.sv
module sct_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sct_pkg::bundle_t     data_i,
  output logic                 full_o,
  output sct_pkg::queue_head_t head_o,
  input  logic                 pop_i
);
  import sct_pkg::*;

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o      = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.data  = mem_q[rd_q];

  // two-entry bundle queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

### sv/sct_back.sv
module sct_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sct_pkg::queue_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sct_pkg::out_item_t   out_item_o
);
  import sct_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  out_item_t  tok_sel;
  logic       load, last;

  assign load        = head_i.valid && (!out_valid_q || !out_stall_i);
  assign last        = (idx_q == head_i.data.count - 2'd1);
  assign pop_o       = load && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // selected token with its run flag
  always_comb begin
    tok_sel             = head_i.data.tok[idx_q];
    tok_sel.last_of_run = last;
  end

  // serialize the head bundle one token per cycle while the output is not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= tok_sel;
    end
  end

endmodule

### sv/sct_checker.sv
module sct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sct_pkg::out_item_t out_item_o
);
  import sct_pkg::*;

  // stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // end token closes its run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.token_kind == K_END |-> out_item_o.last_of_run)
    else $error("end token not last of run");

  // newline token is one byte
  a_nl_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.token_kind == K_NEWLINE |-> out_item_o.token_length == 16'd1)
    else $error("newline token length");

  // kind code in range
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.token_kind <= K_LAST)
    else $error("token kind out of range");

endmodule

bind source_code_tokenizer sct_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sct_pkg::*;

  // scanner modes of the predictor
  typedef enum logic [3:0] {
    MD_IDLE, MD_COMMENT, MD_SDQ, MD_SSQ, MD_SDQ_ESC, MD_SSQ_ESC, MD_NUM, MD_NUMDOT,
    MD_FRAC, MD_WORD, MD_MINUS, MD_ARROW, MD_EQ, MD_LT, MD_GT
  } mode_e;

  // token scoreboard: predicts tokens for each accepted item, checks each emitted one
  class token_scoreboard;
    mode_e       mode;
    logic [31:0] pos;
    logic [31:0] origin;
    logic [23:0] line;
    logic [47:0] prefix;
    logic [3:0]  wlen;
    out_item_t   pending[$];
    out_item_t   staged[$];
    int          errors;

    function void clear_state();
      mode = MD_IDLE;
      pos = '0;
      origin = '0;
      line = 24'd1;
      prefix = '0;
      wlen = '0;
    endfunction

    function logic [31:0] bump(logic [31:0] p);
      return (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
    endfunction

    function logic [15:0] span(logic [31:0] from, logic [31:0] to);
      if (to <= from) return '0;
      return ((to - from) > 32'd65535) ? 16'hFFFF : 16'(to - from);
    endfunction

    function void line_up();
      if (line != 24'hFF_FFFF) line = line + 24'd1;
    endfunction

    function void push_token(logic [5:0] kind, logic [31:0] start, logic [15:0] len);
      out_item_t t;
      t.token_kind = kind;
      t.token_start = start;
      t.token_length = len;
      t.line_number = line;
      t.last_of_run = 1'b0;
      if (staged.size() < MAX_TOKENS) staged.insert(staged.size(), t);
    endfunction

    function logic [5:0] classify_word();
      logic [5:0] kind;
      kind = K_IDENT;
      for (int k = 0; k < NUM_KEYWORDS; k++)
        if (wlen == {1'b0, KW_LEN[k]} && prefix == KW_TEXT[k]) begin
          kind = K_KEYWORD0 + 6'(k);
          break;
        end
      return kind;
    endfunction

    function void start_token(logic [7:0] c, logic [31:0] p);
      mode = MD_IDLE;
      case (c)
        " ", "\r", "\t": ;
        "\n": begin
          line_up();
          push_token(K_NEWLINE, p, 16'd1);
        end
        "#": mode = MD_COMMENT;
        "(": push_token(K_LPAREN, p, 16'd1);
        ")": push_token(K_RPAREN, p, 16'd1);
        "{": push_token(K_LBRACE, p, 16'd1);
        "}": push_token(K_RBRACE, p, 16'd1);
        "[": push_token(K_LSQUARE, p, 16'd1);
        "]": push_token(K_RSQUARE, p, 16'd1);
        ",": push_token(K_COMMA, p, 16'd1);
        ".": push_token(K_DOT, p, 16'd1);
        ":": push_token(K_COLON, p, 16'd1);
        "+": push_token(K_PLUS, p, 16'd1);
        "/": push_token(K_SLASH, p, 16'd1);
        "*": push_token(K_STAR, p, 16'd1);
        "-": begin mode = MD_MINUS; origin = p; end
        "=": begin mode = MD_EQ; origin = p; end
        "<": begin mode = MD_LT; origin = p; end
        ">": begin mode = MD_GT; origin = p; end
        "\"": begin mode = MD_SDQ; origin = bump(p); end
        "'": begin mode = MD_SSQ; origin = bump(p); end
        default: begin
          if (c >= "0" && c <= "9") begin
            mode = MD_NUM;
            origin = p;
          end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
            mode = MD_WORD;
            origin = p;
            prefix = {40'd0, c};
            wlen = 4'd1;
          end else begin
            push_token(K_ERR_BYTE, p, 16'd1);
          end
        end
      endcase
    endfunction

    function void scan(logic [7:0] c, logic [31:0] p);
      logic digit;
      logic alpha;
      digit = (c >= "0" && c <= "9");
      alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      case (mode)
        MD_COMMENT: if (c == "\n") start_token(c, p);
        MD_SDQ, MD_SSQ: begin
          if (c == ((mode == MD_SDQ) ? 8'h22 : 8'h27)) begin
            push_token(K_STRING, origin, span(origin, p));
            mode = MD_IDLE;
          end else if (c == "\\") begin
            mode = (mode == MD_SDQ) ? MD_SDQ_ESC : MD_SSQ_ESC;
          end else if (c == "\n") begin
            line_up();
          end
        end
        MD_SDQ_ESC, MD_SSQ_ESC: begin
          if (c == "\n") line_up();
          mode = (mode == MD_SDQ_ESC) ? MD_SDQ : MD_SSQ;
        end
        MD_NUM: begin
          if (c == ".") mode = MD_NUMDOT;
          else if (!digit) begin
            push_token(K_NUMBER, origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_NUMDOT: begin
          if (digit) mode = MD_FRAC;
          else begin
            push_token(K_NUMBER, origin, span(origin, p - 1));
            push_token(K_DOT, p - 1, 16'd1);
            start_token(c, p);
          end
        end
        MD_FRAC: begin
          if (!digit) begin
            push_token(K_NUMBER, origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_WORD: begin
          if (alpha || digit) begin
            if (wlen < 4'd6) prefix = prefix | (48'(c) << (8 * wlen));
            if (wlen < 4'd7) wlen = wlen + 4'd1;
          end else begin
            push_token(classify_word(), origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_MINUS: begin
          if (c == ">") mode = MD_ARROW;
          else begin
            push_token(K_MINUS, origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_ARROW: begin
          if (c == ">") begin
            push_token(K_DRARROW, origin, span(origin, bump(p)));
            mode = MD_IDLE;
          end else begin
            push_token(K_RARROW, origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_EQ: begin
          if (c == "=" || c == ">") begin
            push_token((c == "=") ? K_EQEQ : K_BIGARROW, origin, span(origin, bump(p)));
            mode = MD_IDLE;
          end else begin
            push_token(K_EQUAL, origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_LT: begin
          if (c == "-" || c == "=") begin
            push_token((c == "-") ? K_LARROW : K_LE, origin, span(origin, bump(p)));
            mode = MD_IDLE;
          end else begin
            push_token(K_LOWER, origin, span(origin, p));
            start_token(c, p);
          end
        end
        MD_GT: begin
          if (c == "=") begin
            push_token(K_GE, origin, span(origin, bump(p)));
            mode = MD_IDLE;
          end else begin
            push_token(K_HIGHER, origin, span(origin, p));
            start_token(c, p);
          end
        end
        default: start_token(c, p);
      endcase
    endfunction

    function void close_source(logic [31:0] p);
      case (mode)
        MD_SDQ, MD_SSQ, MD_SDQ_ESC, MD_SSQ_ESC:
          push_token(K_ERR_STRING, origin, span(origin, p));
        MD_NUM, MD_FRAC: push_token(K_NUMBER, origin, span(origin, p));
        MD_NUMDOT: begin
          push_token(K_NUMBER, origin, span(origin, p - 1));
          push_token(K_DOT, p - 1, 16'd1);
        end
        MD_WORD: push_token(classify_word(), origin, span(origin, p));
        MD_MINUS: push_token(K_MINUS, origin, 16'd1);
        MD_ARROW: push_token(K_RARROW, origin, span(origin, p));
        MD_EQ: push_token(K_EQUAL, origin, 16'd1);
        MD_LT: push_token(K_LOWER, origin, 16'd1);
        MD_GT: push_token(K_HIGHER, origin, 16'd1);
        default: ;
      endcase
      push_token(K_END, p, 16'd0);
    endfunction

    // predict the tokens caused by one accepted item
    function void note_item(in_item_t it);
      staged.delete();
      if (it.end_of_source) begin
        close_source(pos);
        clear_state();
      end else begin
        scan(it.source_byte, pos);
        pos = bump(pos);
      end
      if (staged.size() > 0) staged[staged.size() - 1].last_of_run = 1'b1;
      foreach (staged[i]) pending.insert(pending.size(), staged[i]);
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected token kind=%0d start=%0d", got.token_kind, got.token_start);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
        errors++;
      end
      if (got.token_start !== want.token_start) begin
        $error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
        errors++;
      end
      if (got.token_length !== want.token_length) begin
        $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
        errors++;
      end
      if (got.line_number !== want.line_number) begin
        $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b1;
  out_item_t out_item_o;

  token_scoreboard sb = new();
  int  cycles = 0;
  int  hold_cycles = 0;
  bit  hold_req = 1'b0;
  bit  stim_done = 1'b0;

  source_code_tokenizer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(logic [7:0] b, logic eos);
    in_item_t it;
    it.source_byte = b;
    it.end_of_source = eos;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    send_item(b, 1'b0);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic end_source();
    send_item(8'h00, 1'b1);
  endtask

  // pick a random lexeme, mostly well formed
  function automatic string random_lexeme();
    string words[$] = '{"true", "false", "or", "and", "if", "else", "for", "while",
                        "none", "class", "self", "unroll", "x", "_a9", "unrolled",
                        "Tru", "selfish", "abcdefgh", "i2"};
    string ops[$] = '{"->", "->>", "==", "=>", "<-", "<=", ">=", "-", "=", "<", ">",
                      "(", ")", "{", "}", "[", "]", ",", ".", ":", "+", "/", "*"};
    string s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) s = words[$urandom_range(0, words.size() - 1)];
    else if (r < 45) s = ops[$urandom_range(0, ops.size() - 1)];
    else if (r < 55) s = $sformatf("%0d", $urandom_range(0, 9999));
    else if (r < 62) s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
    else if (r < 66) s = $sformatf("%0d.", $urandom_range(0, 9));
    else if (r < 73) s = ($urandom_range(0, 1)) ? "\"a\\\"b\"" : "'x\\\ny'";
    else if (r < 77) s = "# note\n";
    else if (r < 85) s = "\n";
    else if (r < 92) s = " ";
    else s = string'(8'($urandom_range(1, 255)));
    return s;
  endfunction

  // stimulus
  initial begin
    int n;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: operators, punctuation, numbers, strings, comments, keywords
    send_text("->>-><-<=>===>= -=<>");
    send_text("(){}[],.:+/*\t\r");
    end_source();
    send_text("12.5 7.x 3. while unroll unrolls");
    send_text("#c\n\"q\\\"\n\" 'e\\'");
    end_source();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_text("\"open");
    end_source();

    // receiver holds off while the sender keeps going
    hold_req = 1'b1;
    in_valid_i <= 1'b1;
    for (int i = 0; i < 20; i++) send_item("(", 1'b0);
    hold_req = 1'b0;
    end_source();

    // random sources
    n = 0;
    while (n < 195) begin
      string s;
      s = random_lexeme();
      send_text(s);
      n += s.len();
      if ($urandom_range(0, 19) == 0) begin
        end_source();
        n++;
      end
    end
    end_source();
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_cycles == 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = 1;
        repeat (60) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_stall_i <= (g > 0);
        if (g > 1) repeat (g - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // check emitted tokens
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_token(out_item_o);
  end

  // end of run and timeout
  initial begin
    sb.clear_state();
    sb.errors = 0;
    wait (stim_done);
    while (sb.pending.size() != 0 && cycles < 200000) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (cycles >= 200000) begin
      $display("TB_ERROR");
    end else if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == 250000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

### source_code_tokenizer.f
sv/sct_pkg.sv
sv/sct_front.sv
sv/sct_queue.sv
sv/sct_back.sv
sv/source_code_tokenizer.sv
sv/sct_checker.sv
tb/tb_top.sv
